[hw/rtl/binary_trie_max_xor_macros.svh]
// Assertion macros shared by the binary trie max-XOR RTL.
// Users must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH
`ifndef ASSERT_OFF
`define BTMX_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
`define BTMX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BTMX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTMX_ASSERT(lbl, expr)
`define BTMX_ASSERT_IMP(lbl, ante, cons)
`define BTMX_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/btmx_pkg.sv]
// Package for the binary trie max-XOR block: sizes, codes and the
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package btmx_pkg;

    // Default sizing of the trie.
    localparam int VALUE_BITS_DEF    = 32;
    localparam int NODE_CAPACITY_DEF = 4096;

    // Fixed width of the value and result words on the ports.
    localparam int DATA_W = 32;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic last;
    } t_stat;

endpackage

[hw/rtl/binary_trie_max_xor.sv]
// An accepted insert or query walks the trie one level per step through the link memory's
// registered read, then finishes in a done state that moves the result to the output register.
// The next word is taken only once that result has moved out; a refused insert or an
// empty-trie query skips the walk and goes straight to the done state. A finished
// result waits, and the input stays stalled, for as long as the output register is held.
// Reset: synchronous, active low; the trie becomes empty (root only) at once, with no
// clearing pass over the link memory.
`timescale 1ns / 1ps

module binary_trie_max_xor #(
    parameter int VALUE_BITS    = btmx_pkg::VALUE_BITS_DEF,
    parameter int NODE_CAPACITY = btmx_pkg::NODE_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [btmx_pkg::DATA_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [btmx_pkg::DATA_W-1:0] o_max_xor,
    output logic [1:0]                  o_status
);

    btmx_pkg::t_cmd  w_cmd;
    btmx_pkg::t_stat w_stat;

    // Sequencer.
    btmx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Trie memory and walk datapath.
    btmx_dp #(
        .VALUE_BITS    (VALUE_BITS),
        .NODE_CAPACITY (NODE_CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_op      (i_op),
        .i_value   (i_value),
        .o_max_xor (o_max_xor),
        .o_status  (o_status)
    );

endmodule

[hw/rtl/btmx_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps

module btmx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/btmx_ctrl.sv]
// Controller state machine of the binary trie max-XOR block.
// Depends on btmx_pkg and binary_trie_max_xor_macros.svh.
`timescale 1ns / 1ps
`include "binary_trie_max_xor_macros.svh"

module btmx_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  btmx_pkg::t_stat i_stat,
    output btmx_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_emit;

    // A word is taken only while idle; a result moves out once the output register is free.
    assign w_accept = i_in_valid && !r_in_stall;
    assign w_emit   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign o_cmd.load = w_accept;
    assign o_cmd.step = (r_state == S_WALK);
    assign o_cmd.emit = w_emit;

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces the taken one; otherwise a taken result clears the flag.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in_stall <= 1'b1;
                        r_state    <= i_stat.skip ? S_DONE : S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_stat.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_emit) begin
                        r_in_stall  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A finished result waits while the output register is still held.
    `BTMX_ASSERT_NXT(a_done_holds, r_state == S_DONE && r_out_valid && i_out_stall,
                     r_state == S_DONE)
    // A new result appears only out of the done state.
    `BTMX_ASSERT_IMP(a_rise_from_done, $rose(r_out_valid), $past(r_state) == S_DONE)
    // The input stall tracks the busy states.
    `BTMX_ASSERT(a_stall_busy, r_in_stall == (r_state != S_IDLE))

endmodule

[hw/rtl/btmx_dp.sv]
// Datapath of the binary trie max-XOR block: link memory, walk registers,
// node allocator and result register. Depends on btmx_pkg, btmx_ram and the macros header.
`timescale 1ns / 1ps
`include "binary_trie_max_xor_macros.svh"

module btmx_dp #(
    parameter int VALUE_BITS    = btmx_pkg::VALUE_BITS_DEF,
    parameter int NODE_CAPACITY = btmx_pkg::NODE_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  btmx_pkg::t_cmd              i_cmd,
    output btmx_pkg::t_stat             o_stat,
    input  logic                        i_op,
    input  logic [btmx_pkg::DATA_W-1:0] i_value,
    output logic [btmx_pkg::DATA_W-1:0] o_max_xor,
    output logic [1:0]                  o_status
);

    localparam int DW = btmx_pkg::DATA_W;
    localparam int LW = $clog2(NODE_CAPACITY);
    localparam int UW = $clog2(NODE_CAPACITY + 1);
    localparam int EW = 2 * LW;
    localparam int PW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int VW = (VALUE_BITS > DW) ? VALUE_BITS : DW;

    logic          r_op;
    logic [DW-1:0] r_value;
    logic [LW-1:0] r_node, n_node;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_alloc, n_alloc;
    logic [VW-1:0] r_best, n_best;
    logic [UW-1:0] r_used, n_used;
    logic [1:0]    r_status;
    logic          r_root_ok;
    logic [DW-1:0] r_max_xor;
    logic [1:0]    r_out_status;

    logic [EW-1:0] w_ram_rdata;
    logic [EW-1:0] w_rd;
    logic [EW-1:0] w_wdata;
    logic          w_we;
    logic [VW-1:0] w_vext;
    logic          w_bit;
    logic [LW-1:0] w_link0, w_link1, w_same, w_other, w_new;
    logic          w_dead;
    logic          w_full;
    logic [1:0]    w_load_status;

    // Link memory: one entry per node, upper half is the one-link, lower half the zero-link.
    btmx_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_CAPACITY)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_node),
        .i_wdata (w_wdata),
        .i_raddr (n_node),
        .o_rdata (w_ram_rdata)
    );

    // The root reads as empty until first written; other interior nodes are written whole
    // before they are read and leaves are never read, so stale contents are never seen.
    assign w_rd    = (r_node == '0 && !r_root_ok) ? '0 : w_ram_rdata;
    assign w_link0 = w_rd[LW-1:0];
    assign w_link1 = w_rd[EW-1:LW];

    // Current bit of the value; bits above the port width count as zero.
    assign w_vext  = VW'(r_value);
    assign w_bit   = w_vext[r_pos];
    assign w_same  = w_bit ? w_link1 : w_link0;
    assign w_other = w_bit ? w_link0 : w_link1;
    assign w_new   = r_used[LW-1:0];
    assign w_dead  = (r_op == btmx_pkg::OP_QUERY) && (w_same == '0) && (w_other == '0);

    // Status decided when a word is taken: empty trie or too few free nodes.
    assign w_full = ((UW + 1)'(r_used) + (UW + 1)'(VALUE_BITS)) > (UW + 1)'(NODE_CAPACITY);

    always_comb begin
        if (i_op == btmx_pkg::OP_QUERY) begin
            w_load_status = (r_used <= UW'(1)) ? btmx_pkg::STATUS_EMPTY : btmx_pkg::STATUS_OK;
        end else begin
            w_load_status = w_full ? btmx_pkg::STATUS_FULL : btmx_pkg::STATUS_OK;
        end
    end

    assign o_stat.skip = (w_load_status != btmx_pkg::STATUS_OK);
    assign o_stat.last = (r_pos == '0) || w_dead;

    // One trie level per step: follow, prefer the opposite link, or allocate.
    always_comb begin
        n_node  = r_node;
        n_pos   = r_pos;
        n_alloc = r_alloc;
        n_best  = r_best;
        n_used  = r_used;
        w_we    = 1'b0;
        w_wdata = w_rd;
        if (i_cmd.load) begin
            n_node  = '0;
            n_pos   = PW'(VALUE_BITS - 1);
            n_alloc = 1'b0;
            n_best  = '0;
        end else if (i_cmd.step) begin
            n_pos = r_pos - PW'(1);
            if (r_op == btmx_pkg::OP_QUERY) begin
                if (w_other != '0) begin
                    n_best[r_pos] = 1'b1;
                    n_node        = w_other;
                end else if (w_same != '0) begin
                    n_node = w_same;
                end
            end else if (r_alloc) begin
                w_we    = 1'b1;
                w_wdata = w_bit ? {w_new, LW'(0)} : {LW'(0), w_new};
                n_node  = w_new;
                n_used  = r_used + UW'(1);
            end else if (w_same != '0) begin
                n_node = w_same;
            end else begin
                w_we    = 1'b1;
                w_wdata = w_bit ? {w_new, w_link0} : {w_link1, w_new};
                n_node  = w_new;
                n_used  = r_used + UW'(1);
                n_alloc = 1'b1;
            end
        end
    end

    // Walk, allocator and trie-level state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= UW'(1);
            r_root_ok <= 1'b0;
            r_alloc   <= 1'b0;
            r_op      <= btmx_pkg::OP_INSERT;
            r_best    <= '0;
            r_status  <= btmx_pkg::STATUS_OK;
        end else begin
            r_used  <= n_used;
            r_alloc <= n_alloc;
            r_best  <= n_best;
            if (w_we && r_node == '0) begin
                r_root_ok <= 1'b1;
            end
            if (i_cmd.load) begin
                r_op     <= i_op;
                r_status <= w_load_status;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_pos  <= n_pos;
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (i_cmd.emit) begin
            r_max_xor    <= DW'(r_best);
            r_out_status <= r_status;
        end
    end

    assign o_max_xor = r_max_xor;
    assign o_status  = r_out_status;

    // The allocator never runs past the node pool.
    `BTMX_ASSERT(a_used_cap, r_used <= UW'(NODE_CAPACITY))
    // Allocation mode belongs to inserts only.
    `BTMX_ASSERT_IMP(a_alloc_insert, r_alloc, r_op == btmx_pkg::OP_INSERT)
    // A refused or empty word never collects XOR bits.
    `BTMX_ASSERT_IMP(a_skip_zero, r_status != btmx_pkg::STATUS_OK, r_best == '0)

endmodule
